/* hdl/wfba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared field widths, operation codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package wfba_pkg;

   localparam int OP_W    = 1;
   localparam int IDX_W   = 4;
   localparam int SIZE_W  = 16;
   localparam int REQNO_W = 16;
   localparam int CFG_W   = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;     // write table entry, free it
      logic start;    // latch request, reset scan
      logic issue;    // read next table entry
      logic finish;   // commit pick, load response register
   } wfba_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_end; // all entries in use have been read
      logic out_free; // response register can take a new beat
   } wfba_sts_type;

endpackage
`default_nettype wire

/* hdl/wfba_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_req_if
// Request channel: load or allocate beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wfba_req_if
   import wfba_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [IDX_W-1:0]  block_index;
   logic [SIZE_W-1:0] size;

   modport source (output valid, operation, block_index, size, input ready);
   modport sink   (input valid, operation, block_index, size, output ready);
endinterface
`default_nettype wire

/* hdl/wfba_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_rsp_if
// Response channel: allocation result beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wfba_rsp_if
   import wfba_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               granted;
   logic [IDX_W-1:0]   chosen_block;
   logic [SIZE_W-1:0]  fragment;
   logic [REQNO_W-1:0] request_number;

   modport source (output valid, granted, chosen_block, fragment, request_number,
                   input ready);
   modport sink   (input valid, granted, chosen_block, fragment, request_number,
                   output ready);
endinterface
`default_nettype wire

/* hdl/wfba_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/wfba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_ctrl
// Sequencer: accept, scan the table one entry per cycle, commit the pick.
// ----------------------------------------------------------------------------
module wfba_ctrl
   import wfba_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output      logic            req_ready,
   input  wire wfba_sts_type    sts,
   output      wfba_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load  = accept && (req_operation == OP_LOAD);
            cmd.start = accept && (req_operation == OP_ALLOC);
            if (cmd.start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // last compare lands at the same edge we leave
            if (sts.scan_end) begin
               state_in = S_DONE;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/wfba_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wfba_dp
// Datapath: size table, taken flags, worst-fit compare, response register.
// ----------------------------------------------------------------------------
module wfba_dp
   import wfba_pkg::*;
#(
   parameter int BLOCKS    = 16,
   parameter int SIZE_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [CFG_W-1:0]   csr_wdata,
   input  wire logic [IDX_W-1:0]   req_block_index,
   input  wire logic [SIZE_W-1:0]  req_size,
   input  wire wfba_cmd_type       cmd,
   output      wfba_sts_type       sts,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic               rsp_granted,
   output      logic [IDX_W-1:0]   rsp_chosen_block,
   output      logic [SIZE_W-1:0]  rsp_fragment,
   output      logic [REQNO_W-1:0] rsp_request_number
);

   localparam int IDXW = $clog2(BLOCKS);
   localparam int CNTW = $clog2(BLOCKS + 1);

   logic [CFG_W-1:0]     cfg_ff;
   logic [CNTW-1:0]      limit_in, limit_ff;
   logic [CNTW-1:0]      scan_idx_ff;
   logic [IDXW-1:0]      cmp_idx_ff;
   logic                 cmp_vld_ff;
   logic [SIZE_BITS-1:0] want_ff;
   logic                 found_ff;
   logic [SIZE_BITS-1:0] best_ff;
   logic [IDXW-1:0]      best_idx_ff;
   logic [BLOCKS-1:0]    taken_ff;
   logic [REQNO_W-1:0]   req_cnt_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_granted_ff;
   logic [IDX_W-1:0]     rsp_chosen_ff;
   logic [SIZE_W-1:0]    rsp_frag_ff;
   logic [REQNO_W-1:0]   rsp_reqno_ff;

   logic                 load_ok;
   logic [IDXW-1:0]      load_addr;
   logic [SIZE_BITS-1:0] rd_data;
   logic                 fits;
   logic [SIZE_BITS-1:0] left;
   logic                 better;

   // loads beyond the table are dropped
   assign load_ok   = (32'(req_block_index) < BLOCKS);
   assign load_addr = IDXW'(req_block_index);

   wfba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (BLOCKS)
   ) u_size_ram (
      .clock   (clock),
      .wr_en   (cmd.load && load_ok),
      .wr_addr (load_addr),
      .wr_data (SIZE_BITS'(req_size)),
      .rd_en   (cmd.issue),
      .rd_addr (scan_idx_ff[IDXW-1:0]),
      .rd_data (rd_data)
   );

   // oversized blocks_in_use clamps to the table depth
   always_comb begin
      if (32'(cfg_ff) > BLOCKS) begin
         limit_in = CNTW'(BLOCKS);
      end else begin
         limit_in = CNTW'(cfg_ff);
      end
   end

   assign fits   = cmp_vld_ff && !taken_ff[cmp_idx_ff] && (rd_data >= want_ff);
   assign left   = rd_data - want_ff;
   assign better = fits && (!found_ff || (left > best_ff));

   assign sts.scan_end = (scan_idx_ff >= limit_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   // scan and compare
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.start) begin
            found_ff <= 1'b0;
         end else if (better) begin
            found_ff <= 1'b1;
         end
      end
      if (cmd.start) begin
         limit_ff    <= limit_in;
         want_ff     <= SIZE_BITS'(req_size);
         scan_idx_ff <= '0;
      end else if (cmd.issue) begin
         scan_idx_ff <= scan_idx_ff + CNTW'(1);
      end
      if (cmd.issue) begin
         cmp_idx_ff <= scan_idx_ff[IDXW-1:0];
      end
      if (better) begin
         best_ff     <= left;
         best_idx_ff <= cmp_idx_ff;
      end
   end

   // taken flags and request counter
   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff   <= '0;
         req_cnt_ff <= '0;
      end else begin
         if (cmd.load && load_ok) begin
            taken_ff[load_addr] <= 1'b0;
         end
         if (cmd.finish) begin
            req_cnt_ff <= req_cnt_ff + REQNO_W'(1);
            if (found_ff) begin
               taken_ff[best_idx_ff] <= 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_granted_ff <= found_ff;
         rsp_chosen_ff  <= found_ff ? IDX_W'(best_idx_ff) : '0;
         rsp_frag_ff    <= found_ff ? SIZE_W'(best_ff) : '0;
         rsp_reqno_ff   <= req_cnt_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_chosen_block   = rsp_chosen_ff;
   assign rsp_fragment       = rsp_frag_ff;
   assign rsp_request_number = rsp_reqno_ff;

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over an untaken beat");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !cmp_vld_ff)
      else $error("result committed with a compare still pending");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> (CNTW'(cmp_idx_ff) < limit_ff))
      else $error("compare on entry outside blocks in use");

   a_reqno_step: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (req_cnt_ff == REQNO_W'($past(req_cnt_ff) + REQNO_W'(1))))
      else $error("request counter did not advance on commit");

endmodule
`default_nettype wire

/* hdl/worst_fit_block_allocator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// worst_fit_block_allocator_unit
// Worst-fit allocator over a table of fixed-size memory blocks.
// ----------------------------------------------------------------------------
// A load beat (operation 0) writes one table entry and marks it free; it gives
// no response. An allocate beat (operation 1) scans the first blocks_in_use
// entries (clamped to BLOCKS), picks the free entry whose size is at least the
// request and leaves the largest leftover, lowest index on a tie, marks it
// taken and returns one response beat: granted, the block index, the leftover
// fragment and the running request number (0 after reset, wraps at 65536). An
// exact fit is granted; no fit gives granted 0 with index and fragment 0.
// After accept the scan reads one entry per cycle through the single read port
// of the size table RAM; the last compare then drains, and the pick goes into
// the response register once that register is free. The response register
// lets the next request be taken while a result beat waits on the sink.
// Entries never loaded hold no defined size and must not be scanned.
// blocks_in_use is written through csr_we/csr_wdata; the user must do so
// only while idle, since the block does not enforce it. Reset value is 16,
// and 0 refuses every allocate.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator_unit
   import wfba_pkg::*;
#(
   parameter int BLOCKS    = 16,
   parameter int SIZE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [CFG_W-1:0] csr_wdata,
   wfba_req_if.sink              req_ch,
   wfba_rsp_if.source            rsp_ch
);

   wfba_cmd_type cmd;
   wfba_sts_type sts;
   logic         req_ready;

   // sequencer: owns the request handshake
   wfba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   assign req_ch.ready = req_ready;

   // table, flags, compare and response register
   wfba_dp #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_block_index    (req_ch.block_index),
      .req_size           (req_ch.size),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_granted        (rsp_ch.granted),
      .rsp_chosen_block   (rsp_ch.chosen_block),
      .rsp_fragment       (rsp_ch.fragment),
      .rsp_request_number (rsp_ch.request_number)
   );

endmodule
`default_nettype wire
